// ----- sv/acb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acb_pkg
// shared types, constants and register indexes of the auto-crop bounding box
// ----------------------------------------------------------------------------
package acb_pkg;

  localparam int MAX_DIM = 4096;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int POS_W   = 14;
  localparam int BORD_W  = 8;
  localparam int PIX_W   = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 136;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TRIM_ENABLE   = 3'd0;
  localparam cfg_idx_t CFG_BORDER_LEFT   = 3'd1;
  localparam cfg_idx_t CFG_BORDER_TOP    = 3'd2;
  localparam cfg_idx_t CFG_BORDER_RIGHT  = 3'd3;
  localparam cfg_idx_t CFG_BORDER_BOTTOM = 3'd4;

  typedef struct packed {
    logic              trim_enable;
    logic [BORD_W-1:0] border_left;
    logic [BORD_W-1:0] border_top;
    logic [BORD_W-1:0] border_right;
    logic [BORD_W-1:0] border_bottom;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_value;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic               end_of_image;
  } pix_t;

  // finished box of one image, handed from front to back
  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] min_col;
    logic [COORD_W-1:0] max_col;
    logic [COORD_W-1:0] min_row;
    logic [COORD_W-1:0] max_row;
    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;
  } box_rec_t;

  typedef struct packed {
    logic [DIM_W-1:0] crop_x;
    logic [DIM_W-1:0] crop_y;
    logic [DIM_W-1:0] crop_w;
    logic [DIM_W-1:0] crop_h;
    logic [POS_W-1:0] copy_x;
    logic [POS_W-1:0] copy_y;
    logic [DIM_W-1:0] copy_w;
    logic [DIM_W-1:0] copy_h;
    logic             copy_valid;
    logic [DIM_W-1:0] source_w;
    logic [DIM_W-1:0] source_h;
  } result_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage
`default_nettype wire

// ----- sv/acb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acb_front
// background latch and content box tracking, one pixel per cycle while accept is high
// ----------------------------------------------------------------------------
module acb_front
  import acb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire pix_t     item,
  input  wire logic     trim_enable,
  output logic          push,
  output box_rec_t      rec
);

  logic [PIX_W-1:0]   bg_r, bg_nxt;
  logic [COORD_W-1:0] min_col_r, min_col_nxt, max_col_r, max_col_nxt;
  logic [COORD_W-1:0] min_row_r, min_row_nxt, max_row_r, max_row_nxt;
  logic               found_r, found_nxt;

  logic [COORD_W-1:0] t_min_col, t_max_col, t_min_row, t_max_row;
  logic               t_found;
  logic               origin;
  logic [DIM_W-1:0]   w_sat, h_sat;

  assign origin = (item.column == '0) && (item.row == '0);
  assign w_sat  = (item.image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : item.image_width;
  assign h_sat  = (item.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : item.image_height;

  // box after this pixel
  always_comb begin
    bg_nxt    = bg_r;
    t_min_col = min_col_r;
    t_max_col = max_col_r;
    t_min_row = min_row_r;
    t_max_row = max_row_r;
    t_found   = found_r;
    if (origin) begin
      bg_nxt    = item.pixel_value;
      t_min_col = '1;
      t_max_col = '0;
      t_min_row = '1;
      t_max_row = '0;
      t_found   = 1'b0;
    end else if (item.pixel_value != bg_r) begin
      if (!found_r || item.column < min_col_r) t_min_col = item.column;
      if (!found_r || item.column > max_col_r) t_max_col = item.column;
      if (!found_r || item.row < min_row_r)    t_min_row = item.row;
      if (!found_r || item.row > max_row_r)    t_max_row = item.row;
      t_found = 1'b1;
    end
  end

  always_comb begin
    min_col_nxt = t_min_col;
    max_col_nxt = t_max_col;
    min_row_nxt = t_min_row;
    max_row_nxt = t_max_row;
    found_nxt   = t_found;
    if (item.end_of_image) begin
      min_col_nxt = '1;
      max_col_nxt = '0;
      min_row_nxt = '1;
      max_row_nxt = '0;
      found_nxt   = 1'b0;
    end
  end

  assign push        = accept && item.end_of_image && trim_enable;
  assign rec.found   = t_found;
  assign rec.min_col = t_min_col;
  assign rec.max_col = t_max_col;
  assign rec.min_row = t_min_row;
  assign rec.max_row = t_max_row;
  assign rec.src_w   = w_sat;
  assign rec.src_h   = h_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r      <= '0;
      min_col_r <= '1;
      max_col_r <= '0;
      min_row_r <= '1;
      max_row_r <= '0;
      found_r   <= 1'b0;
    end else if (accept) begin
      bg_r      <= bg_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
      found_r   <= found_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/acb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acb_queue
// two-entry queue of finished boxes between front and back
// ----------------------------------------------------------------------------
module acb_queue
  import acb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire box_rec_t  wr_data,
  input  wire logic      pop,
  output box_rec_t       rd_data,
  output q_status_t      status
);

  box_rec_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign status.full      = (count_r == 2'd2);
  assign status.not_empty = (count_r != 2'd0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign rd_data          = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/acb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acb_back
// crop and copy rectangle arithmetic with registered result
// ----------------------------------------------------------------------------
module acb_back
  import acb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire box_rec_t  rec,
  input  wire logic      rec_valid,
  output logic           pop,
  input  wire cfg_t      cfg,
  output logic           res_valid,
  input  wire logic      res_ready,
  output result_t        res
);

  result_t          res_r, res_nxt;
  logic             valid_r, valid_nxt;
  logic [DIM_W-1:0] cx, cy, cw, ch;

  assign pop = rec_valid && (!valid_r || res_ready);

  always_comb begin
    if (rec.found) begin
      cx = DIM_W'(rec.min_col);
      cy = DIM_W'(rec.min_row);
      cw = DIM_W'(rec.max_col) - DIM_W'(rec.min_col) + DIM_W'(1);
      ch = DIM_W'(rec.max_row) - DIM_W'(rec.min_row) + DIM_W'(1);
    end else begin
      cx = rec.src_w;
      cy = rec.src_h;
      cw = '0;
      ch = '0;
    end
    res_nxt.crop_x     = cx;
    res_nxt.crop_y     = cy;
    res_nxt.crop_w     = cw;
    res_nxt.crop_h     = ch;
    res_nxt.copy_x     = POS_W'(cx) - POS_W'(cfg.border_left);
    res_nxt.copy_y     = POS_W'(cy) - POS_W'(cfg.border_top);
    res_nxt.copy_w     = cw + DIM_W'(cfg.border_left) + DIM_W'(cfg.border_right);
    res_nxt.copy_h     = ch + DIM_W'(cfg.border_top) + DIM_W'(cfg.border_bottom);
    res_nxt.copy_valid = (cw != '0);
    res_nxt.source_w   = rec.src_w;
    res_nxt.source_h   = rec.src_h;
  end

  always_comb begin
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// ----- sv/auto_crop_bounding_box_core.sv -----
// result path: the transfer of the last pixel writes the box queue, and the
// output register then takes the box from the queue
// throughput: one pixel per cycle; one result per image while trim is enabled, at most one per cycle
// in_tready drops only while the two-entry box queue is full
// reset: synchronous active-low rst_n; trim enabled, borders zero, background
// zero, box trackers empty, queue and output register empty
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// auto_crop_bounding_box_core
// auto-crop bounding box: content box and copy rectangle per image
// ----------------------------------------------------------------------------
module auto_crop_bounding_box_core
  import acb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // pixel_value, column, row, image_width, image_height, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // crop_x, crop_y, crop_w, crop_h, copy_x, copy_y, copy_w, copy_h,
  // source_w, source_h, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // copy_valid
  output logic                        out_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  pix_t      item;
  logic      accept;
  logic      push, pop;
  box_rec_t  rec_in, rec_out;
  q_status_t q_status;
  result_t   res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIM_ENABLE:   cfg_nxt.trim_enable   = cfg_wdata[0];
        CFG_BORDER_LEFT:   cfg_nxt.border_left   = cfg_wdata;
        CFG_BORDER_TOP:    cfg_nxt.border_top    = cfg_wdata;
        CFG_BORDER_RIGHT:  cfg_nxt.border_right  = cfg_wdata;
        CFG_BORDER_BOTTOM: cfg_nxt.border_bottom = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trim_enable   <= 1'b1;
      cfg_r.border_left   <= '0;
      cfg_r.border_top    <= '0;
      cfg_r.border_right  <= '0;
      cfg_r.border_bottom <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign item.pixel_value  = in_tdata[31:0];
  assign item.column       = in_tdata[43:32];
  assign item.row          = in_tdata[55:44];
  assign item.image_width  = in_tdata[68:56];
  assign item.image_height = in_tdata[81:69];
  assign item.end_of_image = in_tlast;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  acb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (item),
    .trim_enable (cfg_r.trim_enable),
    .push        (push),
    .rec         (rec_in)
  );

  acb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (rec_in),
    .pop     (pop),
    .rd_data (rec_out),
    .status  (q_status)
  );

  acb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (rec_out),
    .rec_valid (q_status.not_empty),
    .pop       (pop),
    .cfg       (cfg_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {4'b0000, res.source_h, res.source_w, res.copy_h, res.copy_w,
                      res.copy_y, res.copy_x, res.crop_h, res.crop_w, res.crop_y,
                      res.crop_x};
  assign out_tuser = res.copy_valid;

endmodule
`default_nettype wire

// ----- sv/acb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acb_checker
// port-level checks of the result channel
// ----------------------------------------------------------------------------
module acb_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata,
  input wire logic         out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[38:26] != 13'd0)))
    else $error("copy_valid disagrees with crop_w");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[51:39] == 13'd0))
    else $error("empty box with nonzero crop_h");

  a_widen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[92:80] >= out_tdata[38:26]) &&
                   (out_tdata[105:93] >= out_tdata[51:39]))
    else $error("copy rectangle narrower than crop box");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind auto_crop_bounding_box_core acb_checker u_acb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the auto-crop bounding box core: streams images
// pixel by pixel, predicts each crop and copy rectangle from its own copy of
// the box trackers and registers, and checks every result transfer in order
// ----------------------------------------------------------------------------
module tb;
  import acb_pkg::*;

  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM);

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  auto_crop_bounding_box_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  bit               trim_on = 1'b1;
  logic [7:0]       pad_left = '0, pad_top = '0, pad_right = '0, pad_bottom = '0;

  // box tracker mirror
  logic [PIX_W-1:0]   bg_pixel = '0;
  logic [COORD_W-1:0] lo_col = '1, hi_col = '0, lo_row = '1, hi_row = '0;
  bit                 have_content = 1'b0;

  result_t pending_crops[$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  bit      steady_flow = 1'b0;

  function automatic void clear_box();
    lo_col = '1;
    hi_col = '0;
    lo_row = '1;
    hi_row = '0;
    have_content = 1'b0;
  endfunction

  task automatic predict_crop(input pix_t p);
    logic [DIM_W-1:0] w, h, cx, cy, cw, ch;
    result_t r;
    w = (p.image_width > MAX_DIM) ? DIM_CAP : p.image_width;
    h = (p.image_height > MAX_DIM) ? DIM_CAP : p.image_height;
    if (p.column == 0 && p.row == 0) begin
      bg_pixel = p.pixel_value;
      clear_box();
    end else if (p.pixel_value != bg_pixel) begin
      if (!have_content || p.column < lo_col) lo_col = p.column;
      if (!have_content || p.column > hi_col) hi_col = p.column;
      if (!have_content || p.row < lo_row) lo_row = p.row;
      if (!have_content || p.row > hi_row) hi_row = p.row;
      have_content = 1'b1;
    end
    if (p.end_of_image) begin
      if (have_content) begin
        cx = {1'b0, lo_col};
        cy = {1'b0, lo_row};
        cw = {1'b0, hi_col} - {1'b0, lo_col} + 13'd1;
        ch = {1'b0, hi_row} - {1'b0, lo_row} + 13'd1;
      end else begin
        cx = w;
        cy = h;
        cw = '0;
        ch = '0;
      end
      clear_box();
      if (trim_on) begin
        r.crop_x     = cx;
        r.crop_y     = cy;
        r.crop_w     = cw;
        r.crop_h     = ch;
        r.copy_x     = {1'b0, cx} - {6'b0, pad_left};
        r.copy_y     = {1'b0, cy} - {6'b0, pad_top};
        r.copy_w     = cw + pad_left + pad_right;
        r.copy_h     = ch + pad_top + pad_bottom;
        r.copy_valid = (cw != 0);
        r.source_w   = w;
        r.source_h   = h;
        pending_crops.push_back(r);
      end
    end
  endtask

  function automatic pix_t make_pixel(input logic [31:0] v, input int c, input int r,
                                      input int w, input int h, input bit last);
    pix_t p;
    p.pixel_value  = v;
    p.column       = 12'(c);
    p.row          = 12'(r);
    p.image_width  = 13'(w);
    p.image_height = 13'(h);
    p.end_of_image = last;
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, p.image_height, p.image_width, p.row, p.column, p.pixel_value};
    in_tlast  <= p.end_of_image;
    do @(posedge clk); while (!in_tready);
    predict_crop(p);
    items_sent++;
  endtask

  // raster image; pixels from skip_origin up to stop-1, tlast on the true last
  // pixel or, if mark_last, on the last one sent
  task automatic send_image(input int w, input int h, input logic [31:0] bg,
                            input int density, input bit skip_origin, input int stop,
                            input bit mark_last, input int size_w, input int size_h);
    logic [31:0] v;
    int idx;
    for (idx = skip_origin ? 1 : 0; idx < stop; idx++) begin
      v = bg;
      if (idx != 0 && $urandom_range(1, 100) <= density) begin
        if ($urandom_range(0, 1)) v = $urandom();
        else v = bg ^ (32'h1 << $urandom_range(0, 31));
      end
      send_pixel(make_pixel(v, idx % w, idx / w, size_w, size_h,
                            (idx == stop - 1) && (mark_last || stop == w * h)));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_crops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TRIM_ENABLE:   trim_on = val[0];
      CFG_BORDER_LEFT:   pad_left = val;
      CFG_BORDER_TOP:    pad_top = val;
      CFG_BORDER_RIGHT:  pad_right = val;
      CFG_BORDER_BOTTOM: pad_bottom = val;
      default: ;
    endcase
  endtask

  task automatic set_borders(input logic [7:0] l, input logic [7:0] t,
                             input logic [7:0] r, input logic [7:0] b);
    write_reg(CFG_BORDER_LEFT, l);
    write_reg(CFG_BORDER_TOP, t);
    write_reg(CFG_BORDER_RIGHT, r);
    write_reg(CFG_BORDER_BOTTOM, b);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: random stall before each transfer
  initial begin : result_sink
    int stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : crop_checker
    result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.crop_x     = out_tdata[12:0];
      got.crop_y     = out_tdata[25:13];
      got.crop_w     = out_tdata[38:26];
      got.crop_h     = out_tdata[51:39];
      got.copy_x     = out_tdata[65:52];
      got.copy_y     = out_tdata[79:66];
      got.copy_w     = out_tdata[92:80];
      got.copy_h     = out_tdata[105:93];
      got.source_w   = out_tdata[118:106];
      got.source_h   = out_tdata[131:119];
      got.copy_valid = out_tuser;
      if (pending_crops.size() == 0) begin
        $display("%0t: unexpected result, expected none got tdata %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_crops.pop_front();
        check_field("crop_x", want.crop_x, got.crop_x);
        check_field("crop_y", want.crop_y, got.crop_y);
        check_field("crop_w", want.crop_w, got.crop_w);
        check_field("crop_h", want.crop_h, got.crop_h);
        check_field("copy_x", want.copy_x, got.copy_x);
        check_field("copy_y", want.copy_y, got.copy_y);
        check_field("copy_w", want.copy_w, got.copy_w);
        check_field("copy_h", want.copy_h, got.copy_h);
        check_field("copy_valid", want.copy_valid, got.copy_valid);
        check_field("source_w", want.source_w, got.source_w);
        check_field("source_h", want.source_h, got.source_h);
      end
    end
  end

  task automatic test_directed_images();
    // no origin pixel after reset, corner coordinates
    send_pixel(make_pixel(32'hFFFF_FFFF, 4095, 4095, 4096, 4096, 1'b1));
    // empty image, oversized width and zero height
    send_pixel(make_pixel(32'hA5A5_A5A5, 0, 0, 8191, 0, 1'b0));
    send_pixel(make_pixel(32'hA5A5_A5A5, 1, 0, 8191, 0, 1'b1));
    // content spanning the full coordinate range
    send_pixel(make_pixel(32'h0000_0000, 0, 0, 4096, 4096, 1'b0));
    send_pixel(make_pixel(32'h0000_0001, 4095, 0, 4096, 4096, 1'b0));
    send_pixel(make_pixel(32'h8000_0000, 0, 4095, 4096, 4096, 1'b0));
    send_pixel(make_pixel(32'h0000_0000, 4095, 4095, 4096, 4096, 1'b1));
    // background kept across images, coordinates outside the image
    send_pixel(make_pixel(32'h0000_0000, 3, 1, 3, 2, 1'b0));
    send_pixel(make_pixel(32'h0000_0005, 200, 7, 3, 2, 1'b1));
    // single-pixel image
    send_pixel(make_pixel(32'h0F0F_0F0F, 0, 0, 1, 1, 1'b1));
    settle();
  endtask

  task automatic test_borders();
    set_borders(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(make_pixel(32'h0000_0000, 0, 0, 4096, 4096, 1'b0));
    send_pixel(make_pixel(32'h0000_0001, 0, 1, 4096, 4096, 1'b0));
    send_pixel(make_pixel(32'h0000_0002, 4095, 4095, 4096, 4096, 1'b1));
    send_pixel(make_pixel(32'h0000_0007, 0, 0, 4096, 4096, 1'b1));
    settle();
    set_borders(8'd1, 8'd0, 8'd255, 8'd7);
    send_image(3, 2, $urandom(), 50, 1'b0, 6, 1'b1, 3, 2);
    settle();
    set_borders(8'd0, 8'd255, 8'd0, 8'd255);
    send_image(1, 2, 32'h5555_5555, 100, 1'b0, 2, 1'b1, 1, 2);
    settle();
  endtask

  task automatic test_trim_disable();
    write_reg(CFG_TRIM_ENABLE, 8'd0);
    send_image(2, 2, 32'h1234_5678, 60, 1'b0, 4, 1'b1, 2, 2);
    send_image(2, 1, 32'hDEAD_BEEF, 50, 1'b0, 2, 1'b1, 2, 1);
    settle();
    write_reg(CFG_TRIM_ENABLE, 8'd1);
    // no origin pixel: background comes from the unreported image
    send_image(3, 1, 32'hDEAD_BEEF, 40, 1'b1, 3, 1'b1, 3, 1);
    settle();
  endtask

  function automatic logic [7:0] pick_border();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_images();
    int start, w, h, sw, sh, k, n;
    start = items_sent;
    while (items_sent - start < 500) begin
      steady_flow = ($urandom_range(0, 5) == 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
      h = (w > 6) ? $urandom_range(1, 2) : $urandom_range(1, 4);
      sw = w;
      sh = h;
      if ($urandom_range(0, 7) == 0) begin
        sw = $urandom_range(0, 8191);
        sh = $urandom_range(0, 8191);
      end
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
              send_pixel(make_pixel($urandom(), 0, 0, $urandom_range(0, 8191),
                                    $urandom_range(0, 8191), $urandom_range(0, 1)));
            else
              send_pixel(make_pixel($urandom(), $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), $urandom_range(0, 8191),
                                    $urandom_range(0, 8191), $urandom_range(0, 1)));
          end
        end
        1: send_image(w, h, $urandom(), $urandom_range(0, 100), $urandom_range(0, 1),
                      $urandom_range(2, w * h + 1) - 1, $urandom_range(0, 1), sw, sh);
        default: send_image(w, h, $urandom(), $urandom_range(0, 4) == 0 ? 0 :
                            $urandom_range(1, 100), ($urandom_range(0, 11) == 0),
                            w * h, 1'b1, sw, sh);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        steady_flow = 1'b0;
        settle();
        write_reg(CFG_TRIM_ENABLE, {7'd0, ($urandom_range(0, 7) != 0)});
        set_borders(pick_border(), pick_border(), pick_border(), pick_border());
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_images();
    test_borders();
    test_trim_disable();
    test_random_images();
    settle();
    if (mismatch_count == 0 && pending_crops.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/acb_pkg.sv
sv/acb_front.sv
sv/acb_queue.sv
sv/acb_back.sv
sv/auto_crop_bounding_box_core.sv
sv/acb_checker.sv
tb/sv/tb.sv
